// ===== hw/rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// shared constants, codes and controller/datapath interface types for the
// partial pivot selector
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_VALUE_BITS = 32;

    localparam int ACTION_W  = 2;
    localparam int SLOT_W    = 6;
    localparam int ITEM_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int MAG_W     = 32;
    localparam int ROWS_W    = 7;
    localparam int TOL_W     = 31;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [TOL_W-1:0]  TOL_RESET  = '0;

    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_TOLERANCE   = 1'b1;

    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_PIVOT = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_SINGULAR = 2'd1,
        STAT_RANGE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_SCAN,
        ST_DECIDE,
        ST_SWAP_B
    } t_state;

    typedef enum logic [1:0] {
        WSEL_CLEAR,
        WSEL_SET,
        WSEL_SWAP_A,
        WSEL_SWAP_B
    } t_wsel;

    typedef enum logic [1:0] {
        EMIT_ROW,
        EMIT_RANGE,
        EMIT_READ,
        EMIT_PIVOT
    } t_emit;

    typedef struct packed {
        logic    capture;
        logic    clear_step;
        logic    ro_we;
        t_wsel   ro_wsel;
        logic    ro_rd_pos;
        logic    col_we;
        logic    scan_start;
        logic    scan_run;
        logic    emit;
        t_emit   emit_sel;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    pos_ok;
        logic    row_ok;
        logic    clear_last;
        logic    scan_idle;
        logic    pivot_ok;
    } t_sts;

endpackage

// ===== hw/rtl/pps_ram.sv =====
// ----------------------------------------------------------------------------
// pps_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pps_ctrl.sv =====
// ----------------------------------------------------------------------------
// pps_ctrl
// controller state machine: clearing pass, item dispatch, pivot scan
// sequencing, swap and result beat
// ----------------------------------------------------------------------------
module pps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  pps_pkg::t_sts i_sts,
    output pps_pkg::t_cmd o_cmd
);

    import pps_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_sts.act)
                    ACT_READ:  n_state = i_sts.pos_ok ? ST_READ : ST_IDLE;
                    ACT_PIVOT: n_state = i_sts.pos_ok ? ST_SCAN : ST_IDLE;
                    ACT_SET, ACT_LOAD: n_state = ST_IDLE;
                    default:   n_state = ST_IDLE;
                endcase
            end
            ST_READ: n_state = ST_IDLE;
            ST_SCAN: begin
                if (i_sts.scan_idle) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: n_state = i_sts.pivot_ok ? ST_SWAP_B : ST_IDLE;
            ST_SWAP_B: n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.ro_wsel  = WSEL_CLEAR;
        cmd.emit_sel = EMIT_ROW;
        unique case (r_state)
            ST_CLEAR: begin
                cmd.ro_we      = 1'b1;
                cmd.ro_wsel    = WSEL_CLEAR;
                cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                cmd.capture = i_start;
            end
            ST_DISPATCH: begin
                unique case (i_sts.act)
                    ACT_SET: begin
                        if (i_sts.pos_ok) begin
                            cmd.ro_we    = 1'b1;
                            cmd.ro_wsel  = WSEL_SET;
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EMIT_ROW;
                        end else begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EMIT_RANGE;
                        end
                    end
                    ACT_LOAD: begin
                        if (i_sts.row_ok) begin
                            cmd.col_we   = 1'b1;
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EMIT_ROW;
                        end else begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EMIT_RANGE;
                        end
                    end
                    ACT_READ: begin
                        if (i_sts.pos_ok) begin
                            cmd.ro_rd_pos = 1'b1;
                        end else begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EMIT_RANGE;
                        end
                    end
                    ACT_PIVOT: begin
                        if (i_sts.pos_ok) begin
                            cmd.scan_start = 1'b1;
                        end else begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EMIT_RANGE;
                        end
                    end
                    default: begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EMIT_RANGE;
                    end
                endcase
            end
            ST_READ: begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EMIT_READ;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
            end
            ST_DECIDE: begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EMIT_PIVOT;
                if (i_sts.pivot_ok) begin
                    cmd.ro_we   = 1'b1;
                    cmd.ro_wsel = WSEL_SWAP_A;
                end
            end
            ST_SWAP_B: begin
                cmd.ro_we   = 1'b1;
                cmd.ro_wsel = WSEL_SWAP_B;
            end
            default: begin
                cmd.ro_wsel = WSEL_CLEAR;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != ST_IDLE);

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> o_busy)
        else $error("accepted beat did not raise busy");

    a_scan_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_start |=> (r_state == ST_SCAN))
        else $error("scan start without scan state");

    a_decide_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> ($past(r_state) == ST_SCAN && $past(i_sts.scan_idle)))
        else $error("pivot decided before scan drained");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.ro_we && cmd.scan_run))
        else $error("row order written during scan");

endmodule

// ===== hw/rtl/pps_datapath.sv =====
// ----------------------------------------------------------------------------
// pps_datapath
// item registers, row order and column value memories, scan pipeline with
// running maximum, and result registers
// ----------------------------------------------------------------------------
module pps_datapath #(
    parameter int MAX_ROWS   = pps_pkg::DEF_MAX_ROWS,
    parameter int VALUE_BITS = pps_pkg::DEF_VALUE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pps_pkg::t_cmd                       i_cmd,
    output pps_pkg::t_sts                       o_sts,
    input  logic [pps_pkg::ACTION_W-1:0]        i_action,
    input  logic [pps_pkg::SLOT_W-1:0]          i_position,
    input  logic [pps_pkg::SLOT_W-1:0]          i_row,
    input  logic signed [pps_pkg::ITEM_W-1:0]   i_value,
    input  logic [pps_pkg::ROWS_W-1:0]          i_rows_in_use,
    input  logic [pps_pkg::TOL_W-1:0]           i_tolerance,
    output logic                                o_done,
    output logic [pps_pkg::STATUS_W-1:0]        o_status,
    output logic [pps_pkg::SLOT_W-1:0]          o_pivot_row,
    output logic [pps_pkg::MAG_W-1:0]           o_pivot_magnitude
);

    import pps_pkg::*;

    localparam int SW  = $clog2(MAX_ROWS);
    localparam int NW0 = $clog2(MAX_ROWS + 1);
    localparam int NW  = (NW0 > ROWS_W) ? NW0 : ROWS_W;
    localparam int CW  = (VALUE_BITS > TOL_W) ? VALUE_BITS : TOL_W;

    // item registers
    t_action               r_act;
    logic [SLOT_W-1:0]     r_pos;
    logic [SLOT_W-1:0]     r_row;
    logic [VALUE_BITS-1:0] r_val;

    // control
    logic [SW-1:0]         r_clr;
    logic [NW-1:0]         r_issue;
    logic                  r_s1_vld;
    logic                  r_s2_vld;
    logic                  r_s3_vld;
    logic                  r_first;
    logic                  r_out_vld;

    // scan payload
    logic [SW-1:0]         r_s1_slot;
    logic [SW-1:0]         r_s2_slot;
    logic [SLOT_W-1:0]     r_s2_row;
    logic                  r_s2_oob;
    logic [SW-1:0]         r_s3_slot;
    logic [SLOT_W-1:0]     r_s3_row;
    logic [VALUE_BITS-1:0] r_s3_mag;
    logic [SW-1:0]         r_best_slot;
    logic [SLOT_W-1:0]     r_best_row;
    logic [VALUE_BITS-1:0] r_best_mag;
    logic [SLOT_W-1:0]     r_pos_row;

    // result payload
    t_status               r_out_status;
    logic [SLOT_W-1:0]     r_out_row;
    logic [MAG_W-1:0]      r_out_mag;

    logic [NW-1:0]         w_n;
    logic                  w_issue;
    logic                  w_pivot_ok;
    logic                  ro_we;
    logic [SW-1:0]         ro_waddr;
    logic [SLOT_W-1:0]     ro_wdata;
    logic [SW-1:0]         ro_raddr;
    logic [SLOT_W-1:0]     ro_rdata;
    logic [VALUE_BITS-1:0] col_rdata;
    logic [VALUE_BITS-1:0] w_neg;
    logic [VALUE_BITS-1:0] w_abs;

    assign w_n = (NW'(i_rows_in_use) < NW'(MAX_ROWS)) ? NW'(i_rows_in_use) : NW'(MAX_ROWS);
    assign w_issue = i_cmd.scan_run && (r_issue < w_n);
    assign w_pivot_ok = CW'(r_best_mag) > CW'(i_tolerance);

    always_comb begin
        ro_waddr = r_clr;
        ro_wdata = SLOT_W'(r_clr);
        case (i_cmd.ro_wsel)
            WSEL_CLEAR: begin
                ro_waddr = r_clr;
                ro_wdata = SLOT_W'(r_clr);
            end
            WSEL_SET: begin
                ro_waddr = SW'(r_pos);
                ro_wdata = r_row;
            end
            WSEL_SWAP_A: begin
                ro_waddr = SW'(r_pos);
                ro_wdata = r_best_row;
            end
            WSEL_SWAP_B: begin
                ro_waddr = r_best_slot;
                ro_wdata = r_pos_row;
            end
            default: begin
                ro_waddr = r_clr;
                ro_wdata = SLOT_W'(r_clr);
            end
        endcase
    end

    assign ro_we    = i_cmd.ro_we;
    assign ro_raddr = i_cmd.ro_rd_pos ? SW'(r_pos) : r_issue[SW-1:0];

    pps_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_ROWS)
    ) u_row_order (
        .i_clk   (i_clk),
        .i_we    (ro_we),
        .i_waddr (ro_waddr),
        .i_wdata (ro_wdata),
        .i_raddr (ro_raddr),
        .o_rdata (ro_rdata)
    );

    pps_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ROWS)
    ) u_column (
        .i_clk   (i_clk),
        .i_we    (i_cmd.col_we),
        .i_waddr (SW'(r_row)),
        .i_wdata (r_val),
        .i_raddr (SW'(ro_rdata)),
        .o_rdata (col_rdata)
    );

    assign w_neg = ~col_rdata + VALUE_BITS'(1);
    assign w_abs = col_rdata[VALUE_BITS-1] ? w_neg : col_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_issue   <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_first   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + SW'(1);
            end
            if (i_cmd.scan_start) begin
                r_issue <= NW'(r_pos);
                r_first <= 1'b1;
            end else if (w_issue) begin
                r_issue <= r_issue + NW'(1);
            end
            if (r_s3_vld && r_first) begin
                r_first <= 1'b0;
            end
            r_s1_vld  <= w_issue;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= t_action'(i_action);
            r_pos <= i_position;
            r_row <= i_row;
            r_val <= VALUE_BITS'(i_value);
        end
        r_s1_slot <= r_issue[SW-1:0];
        r_s2_slot <= r_s1_slot;
        r_s2_row  <= ro_rdata;
        r_s2_oob  <= NW'(ro_rdata) >= NW'(MAX_ROWS);
        r_s3_slot <= r_s2_slot;
        r_s3_row  <= r_s2_row;
        r_s3_mag  <= r_s2_oob ? '0 : w_abs;
        if (r_s3_vld && (r_first || (r_s3_mag > r_best_mag))) begin
            r_best_slot <= r_s3_slot;
            r_best_row  <= r_s3_row;
            r_best_mag  <= r_s3_mag;
        end
        if (r_s3_vld && r_first) begin
            r_pos_row <= r_s3_row;
        end
        if (i_cmd.emit) begin
            case (i_cmd.emit_sel)
                EMIT_ROW: begin
                    r_out_status <= STAT_OK;
                    r_out_row    <= r_row;
                    r_out_mag    <= '0;
                end
                EMIT_RANGE: begin
                    r_out_status <= STAT_RANGE;
                    r_out_row    <= '0;
                    r_out_mag    <= '0;
                end
                EMIT_READ: begin
                    r_out_status <= STAT_OK;
                    r_out_row    <= ro_rdata;
                    r_out_mag    <= '0;
                end
                EMIT_PIVOT: begin
                    r_out_status <= w_pivot_ok ? STAT_OK : STAT_SINGULAR;
                    r_out_row    <= r_best_row;
                    r_out_mag    <= MAG_W'(r_best_mag);
                end
                default: begin
                    r_out_status <= STAT_RANGE;
                    r_out_row    <= '0;
                    r_out_mag    <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.act        = r_act;
        o_sts.pos_ok     = NW'(r_pos) < w_n;
        o_sts.row_ok     = NW'(r_row) < w_n;
        o_sts.clear_last = (r_clr == SW'(MAX_ROWS - 1));
        o_sts.scan_idle  = !(r_issue < w_n) && !r_s1_vld && !r_s2_vld && !r_s3_vld;
        o_sts.pivot_ok   = w_pivot_ok;
    end

    assign o_done            = r_out_vld;
    assign o_status          = r_out_status;
    assign o_pivot_row       = r_out_row;
    assign o_pivot_magnitude = r_out_mag;

    a_single_result_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |=> !r_out_vld)
        else $error("result beats back to back");

    a_scan_start_slot_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && r_first) |-> (r_s3_slot == SW'(r_pos)))
        else $error("first scanned slot is not the pivot position");

    a_scan_later_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && !r_first) |-> (r_s3_slot != SW'(r_pos)))
        else $error("pivot position scanned twice");

endmodule

// ===== hw/rtl/partial_pivot_selector.sv =====
// ----------------------------------------------------------------------------
// partial_pivot_selector
// partial pivoting row selection: holds a row permutation and one column of
// q16.16 values, answers set/load/read items and runs pivot steps
//
//   channel   signals                                      handshake
//   item in   i_action i_position i_row i_value            start & !busy
//   result    o_status o_pivot_row o_pivot_magnitude       o_done, one cycle
//   config    psel penable pwrite paddr pwdata prdata      apb, pready tied high
//
// set, load and out-of-range items emit their result beat from the dispatch
// state; a slot read emits it from a separate read state. a pivot step runs
// a dispatch state, then one slot per cycle through the row order memory, the
// column memory and the compare, a drain of the scan pipeline, a decide state
// and the result, which also carries the second swap write. after reset a
// clearing pass over all MAX_ROWS slots loads the identity order while busy is
// high; config writes are taken throughout. results cannot be stalled by the
// receiver.
// ----------------------------------------------------------------------------
module partial_pivot_selector #(
    parameter int MAX_ROWS   = pps_pkg::DEF_MAX_ROWS,
    parameter int VALUE_BITS = pps_pkg::DEF_VALUE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pps_pkg::ACTION_W-1:0]        i_action,
    input  logic [pps_pkg::SLOT_W-1:0]          i_position,
    input  logic [pps_pkg::SLOT_W-1:0]          i_row,
    input  logic signed [pps_pkg::ITEM_W-1:0]   i_value,
    output logic                                o_done,
    output logic [pps_pkg::STATUS_W-1:0]        o_status,
    output logic [pps_pkg::SLOT_W-1:0]          o_pivot_row,
    output logic [pps_pkg::MAG_W-1:0]           o_pivot_magnitude,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pps_pkg::PADDR_W-1:0]         paddr,
    input  logic [pps_pkg::PDATA_W-1:0]         pwdata,
    output logic [pps_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    import pps_pkg::*;

    logic [ROWS_W-1:0] r_rows_in_use;
    logic [TOL_W-1:0]  r_tolerance;
    logic              w_cfg_wr;
    t_cmd              cmd;
    t_sts              sts;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_RESET;
            r_tolerance   <= TOL_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_ROWS_IN_USE) begin
                r_rows_in_use <= pwdata[ROWS_W-1:0];
            end else begin
                r_tolerance <= pwdata[TOL_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_TOLERANCE) ? PDATA_W'(r_tolerance)
                                                : PDATA_W'(r_rows_in_use);

    pps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pps_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_action),
        .i_position        (i_position),
        .i_row             (i_row),
        .i_value           (i_value),
        .i_rows_in_use     (r_rows_in_use),
        .i_tolerance       (r_tolerance),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_pivot_row       (o_pivot_row),
        .o_pivot_magnitude (o_pivot_magnitude)
    );

endmodule

// ===== tb/pps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_checker
// watches the item, result and apb channels of the partial pivot selector.
// keeps its own row order, column and register copies, works out the result
// of every accepted item and compares each result beat field by field
// ----------------------------------------------------------------------------
module pps_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_action,
    input  logic [5:0]  i_position,
    input  logic [5:0]  i_row,
    input  logic [31:0] i_value,
    input  logic        i_done,
    input  logic [1:0]  i_status,
    input  logic [5:0]  i_pivot_row,
    input  logic [31:0] i_pivot_magnitude,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);
    import pps_pkg::*;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   prow;
        logic [MAG_W-1:0]    mag;
    } t_outcome;

    logic [SLOT_W-1:0] order_tab [DEF_MAX_ROWS];
    logic [ITEM_W-1:0] col_tab [DEF_MAX_ROWS];
    logic [ROWS_W-1:0] rows_cfg;
    logic [TOL_W-1:0]  tol_cfg;
    t_outcome          awaited_q [$];
    int                fails = 0;

    assign o_fail_count = fails;

    function automatic logic [MAG_W-1:0] magnitude_of(input logic [ITEM_W-1:0] v);
        return v[ITEM_W-1] ? -v : v;
    endfunction

    task automatic apply_item(input t_action act, input logic [SLOT_W-1:0] pos,
                              input logic [SLOT_W-1:0] row, input logic [ITEM_W-1:0] val,
                              output t_outcome res);
        int unsigned       n;
        int unsigned       best;
        int unsigned       k;
        logic [MAG_W-1:0]  best_mag;
        logic [MAG_W-1:0]  m;
        logic [SLOT_W-1:0] tmp;
        n = (rows_cfg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_cfg;
        res.status = STAT_OK;
        res.prow   = '0;
        res.mag    = '0;
        case (act)
            ACT_SET: begin
                if (pos < n) begin
                    order_tab[pos] = row;
                    res.prow = row;
                end else begin
                    res.status = STAT_RANGE;
                end
            end
            ACT_LOAD: begin
                if (row < n) begin
                    col_tab[row] = val;
                    res.prow = row;
                end else begin
                    res.status = STAT_RANGE;
                end
            end
            ACT_READ: begin
                if (pos < n) res.prow = order_tab[pos];
                else res.status = STAT_RANGE;
            end
            default: begin
                if (pos >= n) begin
                    res.status = STAT_RANGE;
                end else begin
                    best = pos;
                    best_mag = magnitude_of(col_tab[order_tab[pos]]);
                    for (k = pos + 1; k < n; k++) begin
                        m = magnitude_of(col_tab[order_tab[k]]);
                        // earliest slot keeps a tie
                        if (m > best_mag) begin
                            best_mag = m;
                            best = k;
                        end
                    end
                    res.prow = order_tab[best];
                    res.mag  = best_mag;
                    if (best_mag > {1'b0, tol_cfg}) begin
                        tmp = order_tab[pos];
                        order_tab[pos] = order_tab[best];
                        order_tab[best] = tmp;
                    end else begin
                        res.status = STAT_SINGULAR;
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome res;
        int k;
        if (!i_rst_n) begin
            for (k = 0; k < DEF_MAX_ROWS; k++) order_tab[k] = SLOT_W'(k);
            rows_cfg = ROWS_RESET;
            tol_cfg  = TOL_RESET;
            awaited_q.delete();
        end else begin
            if (i_done) begin
                if (awaited_q.size() == 0) begin
                    $error("result beat with no item waiting: status %0d row %0d mag %0h",
                           i_status, i_pivot_row, i_pivot_magnitude);
                    fails++;
                end else begin
                    want = awaited_q.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_pivot_row !== want.prow) begin
                        $error("pivot_row: expected %0d, actual %0d", want.prow, i_pivot_row);
                        fails++;
                    end
                    if (i_pivot_magnitude !== want.mag) begin
                        $error("pivot_magnitude: expected %0h, actual %0h",
                               want.mag, i_pivot_magnitude);
                        fails++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_ROWS_IN_USE) rows_cfg = i_pwdata[ROWS_W-1:0];
                else tol_cfg = i_pwdata[TOL_W-1:0];
            end
            if (i_start && !i_busy) begin
                apply_item(t_action'(i_action), i_position, i_row, i_value, res);
                awaited_q.push_back(res);
            end
        end
        o_pending <= awaited_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the partial pivot selector: fills the column,
// runs a directed set of corner items, then random phases over several
// rows_in_use / tolerance settings with random idle gaps on the item side
// ----------------------------------------------------------------------------
module testbench;
    import pps_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 95;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [ACTION_W-1:0]   i_action;
    logic [SLOT_W-1:0]     i_position;
    logic [SLOT_W-1:0]     i_row;
    logic [ITEM_W-1:0]     i_value;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_W-1:0]     o_pivot_row;
    logic [MAG_W-1:0]      o_pivot_magnitude;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    int unsigned sent = 0;
    int          gap_mode = 1;
    int unsigned active_rows = 64;

    partial_pivot_selector i_dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_action, .i_position, .i_row, .i_value,
        .o_done, .o_status, .o_pivot_row, .o_pivot_magnitude,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    pps_checker u_check (
        .i_clk, .i_rst_n,
        .i_start(start), .i_busy(busy),
        .i_action, .i_position, .i_row, .i_value,
        .i_done(o_done), .i_status(o_status), .i_pivot_row(o_pivot_row),
        .i_pivot_magnitude(o_pivot_magnitude),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        case (gap_mode)
            0: return 0;
            1: return $urandom_range(0, 14);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    function automatic logic [ITEM_W-1:0] rand_value();
        logic [ITEM_W-1:0] v;
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: begin
                v = $urandom_range(0, 32'h3_0000);
                return $urandom_range(0, 1) ? -v : v;
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] rand_slot();
        if (active_rows == 0 || $urandom_range(0, 7) == 0) return SLOT_W'($urandom_range(0, 63));
        return SLOT_W'($urandom_range(0, ((active_rows > 64) ? 64 : active_rows) - 1));
    endfunction

    task automatic send_item(input t_action act, input logic [SLOT_W-1:0] pos,
                             input logic [SLOT_W-1:0] row, input logic [ITEM_W-1:0] val);
        int unsigned g;
        g = draw_gap();
        if (g != 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_action   <= act;
        i_position <= pos;
        i_row      <= row;
        i_value    <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    // wait for every result beat and for the block to go idle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ROWS_IN_USE) active_rows = 32'(data[ROWS_W-1:0]);
    endtask

    task automatic set_phase(input logic [PDATA_W-1:0] rows, input logic [PDATA_W-1:0] tol);
        drain();
        write_reg(REG_ROWS_IN_USE, rows);
        write_reg(REG_TOLERANCE, tol);
    endtask

    task automatic run_phase(input int unsigned count);
        int unsigned target;
        logic [SLOT_W-1:0] p;
        target = sent + count;
        while (sent < target) begin
            if ($urandom_range(0, 40) == 0) drain();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 6)) send_item(ACT_LOAD, rand_slot(), rand_slot(),
                                                            rand_value());
                end
                4, 5, 6: begin
                    // elimination sweep down the column
                    p = rand_slot();
                    repeat ($urandom_range(1, 4)) begin
                        send_item(ACT_PIVOT, p, SLOT_W'($urandom_range(0, 63)), $urandom());
                        if ($urandom_range(0, 2) == 0)
                            send_item(ACT_READ, p, SLOT_W'($urandom_range(0, 63)), $urandom());
                        p++;
                    end
                end
                7: send_item(ACT_SET, rand_slot(), SLOT_W'($urandom_range(0, 63)), $urandom());
                8: send_item(ACT_READ, rand_slot(), SLOT_W'($urandom_range(0, 63)), $urandom());
                default: send_item(t_action'($urandom_range(0, 3)),
                                   SLOT_W'($urandom_range(0, 63)),
                                   SLOT_W'($urandom_range(0, 63)), $urandom());
            endcase
        end
    endtask

    initial begin
        logic [PDATA_W-1:0] phase_rows [PHASES];
        logic [PDATA_W-1:0] phase_tol [PHASES];
        int k;
        start      = 1'b0;
        i_rst_n    = 1'b0;
        i_action   = ACT_SET;
        i_position = '0;
        i_row      = '0;
        i_value    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        phase_rows = '{64, 1, 2, 5, 8, 17, 33, 63, 127, 64};
        phase_tol  = '{0, 0, 32'h7fff_ffff, 32'h1_0000, $urandom(),
                       32'h100, $urandom(), 0, 32'h7fff_ffff, $urandom()};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every column entry gets written before any pivot reads it
        for (k = 0; k < 64; k++)
            send_item(ACT_LOAD, SLOT_W'($urandom_range(0, 63)), SLOT_W'(k),
                      (k == 0) ? 32'h8000_0000 : (k == 63) ? 32'h7fff_ffff : rand_value());

        set_phase(64, 0);
        send_item(ACT_READ, 0, 0, 0);
        send_item(ACT_READ, 63, 63, 32'hffff_ffff);
        send_item(ACT_PIVOT, 0, 0, 0);
        send_item(ACT_PIVOT, 63, 0, 0);
        send_item(ACT_SET, 5, 63, 0);
        send_item(ACT_READ, 5, 0, 0);
        send_item(ACT_LOAD, 0, 40, 32'h7fff_ffff);
        send_item(ACT_LOAD, 0, 41, 32'h8000_0001);
        send_item(ACT_PIVOT, 1, 0, 0);

        set_phase(8, 32'h7fff_ffff);
        send_item(ACT_PIVOT, 0, 0, 0);
        send_item(ACT_PIVOT, 1, 0, 0);
        send_item(ACT_PIVOT, 8, 0, 0);
        send_item(ACT_SET, 8, 3, 0);
        send_item(ACT_READ, 63, 0, 0);
        send_item(ACT_LOAD, 0, 8, 32'h1234_5678);
        send_item(ACT_LOAD, 0, 7, 32'hffff_ffff);

        set_phase(0, 0);
        send_item(ACT_PIVOT, 0, 0, 0);
        send_item(ACT_LOAD, 0, 0, 1);
        send_item(ACT_READ, 0, 0, 0);
        send_item(ACT_SET, 0, 0, 0);

        set_phase(127, 1);
        send_item(ACT_LOAD, 0, 63, 1);
        send_item(ACT_SET, 63, 63, 0);
        send_item(ACT_PIVOT, 63, 0, 0);
        send_item(ACT_READ, 63, 0, 0);

        for (k = 0; k < PHASES; k++) begin
            set_phase(phase_rows[k], phase_tol[k]);
            gap_mode = k % 3;
            run_phase(PHASE_ITEMS);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pps_pkg.sv
hw/rtl/pps_ram.sv
hw/rtl/pps_ctrl.sv
hw/rtl/pps_datapath.sv
hw/rtl/partial_pivot_selector.sv
tb/pps_checker.sv
tb/testbench.sv
